FILE: rtl/ple_pkg.sv
`default_nettype none

package ple_pkg;

    // Default sizing of the list
    localparam int PLE_CAPACITY   = 64;
    localparam int PLE_DATA_WIDTH = 32;

    // Fixed widths of the transfer fields
    localparam int PLE_OP_W    = 2;
    localparam int PLE_POS_W   = 7;
    localparam int PLE_VALUE_W = 32;
    localparam int PLE_STAT_W  = 2;

    // Match flags examined per scan cycle
    localparam int PLE_LANES  = 8;
    localparam int PLE_LANE_W = $clog2(PLE_LANES);

    typedef enum logic [PLE_OP_W-1:0] {
        OP_INSERT = 2'd0,
        OP_ERASE  = 2'd1,
        OP_SEARCH = 2'd2
    } t_opcode;

    typedef enum logic [PLE_STAT_W-1:0] {
        ST_OK       = 2'd0,
        ST_BADPOS   = 2'd1,
        ST_FULL     = 2'd2,
        ST_NOTFOUND = 2'd3
    } t_status;

    // Shift commands broadcast to every cell
    typedef struct packed {
        logic ins;
        logic ers;
    } t_cell_ctl;

    // Index of the lowest set flag in one lane group
    function automatic logic [PLE_LANE_W-1:0] ple_first(input logic [PLE_LANES-1:0] v);
        logic [PLE_LANE_W-1:0] r;
        r = '0;
        for (int i = PLE_LANES - 1; i >= 0; i--) begin
            if (v[i]) begin
                r = PLE_LANE_W'(i);
            end
        end
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/ple_cell.sv
`default_nettype none

module ple_cell #(
    parameter int IDX        = 0,
    parameter int DATA_WIDTH = ple_pkg::PLE_DATA_WIDTH,
    parameter int CMPW       = ple_pkg::PLE_POS_W
) (
    input  logic                   i_clk,
    input  ple_pkg::t_cell_ctl     i_ctl,
    input  logic [CMPW-1:0]        i_pos,
    input  logic [CMPW-1:0]        i_count,
    input  logic [DATA_WIDTH-1:0]  i_value,
    input  logic [DATA_WIDTH-1:0]  i_left,
    input  logic [DATA_WIDTH-1:0]  i_right,
    output logic [DATA_WIDTH-1:0]  o_data,
    output logic                   o_hit
);
    import ple_pkg::*;

    localparam logic [CMPW-1:0] MY_IDX = CMPW'(IDX);

    logic [DATA_WIDTH-1:0] r_data;
    logic [DATA_WIDTH-1:0] n_data;

    // Pick the entry for the next cycle: hold, take a neighbor, or load
    always_comb begin
        n_data = r_data;
        if (i_ctl.ins) begin
            if (MY_IDX > i_pos) begin
                n_data = i_left;
            end else if (MY_IDX == i_pos) begin
                n_data = i_value;
            end
        end else if (i_ctl.ers) begin
            if (MY_IDX >= i_pos) begin
                n_data = i_right;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    // Flag a match only for an occupied slot
    assign o_hit  = (r_data == i_value) && (MY_IDX < i_count);
    assign o_data = r_data;

endmodule

`default_nettype wire

FILE: rtl/positional_list_engine_core.sv
// Insert, erase and no-op: result registered in the cycle after the input transfer.
// Search: the match flags of all cells are captured at the transfer, then a
// scan unit checks 8 flags per cycle and waits out an output stall at the end.
// One item in flight; the next is taken in the cycle its result transfers out.
// Synchronous active-low reset clears the count, the FSM and the output valid;
// list entries are not cleared and are read only once written.
`default_nettype none

module positional_list_engine_core #(
    parameter int CAPACITY   = ple_pkg::PLE_CAPACITY,
    parameter int DATA_WIDTH = ple_pkg::PLE_DATA_WIDTH
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [ple_pkg::PLE_OP_W-1:0]      i_opcode,
    input  logic [ple_pkg::PLE_POS_W-1:0]     i_position,
    input  logic [ple_pkg::PLE_VALUE_W-1:0]   i_value,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [ple_pkg::PLE_STAT_W-1:0]    o_status,
    output logic signed [ple_pkg::PLE_POS_W-1:0] o_found_position,
    output logic [ple_pkg::PLE_POS_W-1:0]     o_element_count,
    output logic                              o_is_empty
);
    import ple_pkg::*;

    localparam int CW     = $clog2(CAPACITY + 1);
    localparam int CMPW   = (CW > PLE_POS_W) ? CW : PLE_POS_W;
    localparam int NCHUNK = (CAPACITY + PLE_LANES - 1) / PLE_LANES;
    localparam int MW     = NCHUNK * PLE_LANES;
    localparam int BW     = $clog2(MW);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_SCAN = 2'b10
    } t_state;

    t_state                  r_state, n_state;
    logic [CW-1:0]           r_count, n_count;
    logic [MW-1:0]           r_mvec, n_mvec;
    logic [BW-1:0]           r_base, n_base;
    logic                    r_ovalid, n_ovalid;
    t_status                 r_status, n_status;
    logic [PLE_POS_W-1:0]    r_found, n_found;
    logic [PLE_POS_W-1:0]    r_ocount, n_ocount;
    logic                    r_empty, n_empty;

    t_cell_ctl               w_ctl;
    logic [DATA_WIDTH-1:0]   w_value;
    logic [DATA_WIDTH-1:0]   w_data [CAPACITY];
    logic [MW-1:0]           w_hits;
    logic [CMPW-1:0]         w_pos;
    logic [CMPW-1:0]         w_cnt;
    logic                    w_take_out;
    logic                    w_accept;

    // Fit the value field to the entry width
    generate
        if (DATA_WIDTH <= PLE_VALUE_W) begin : g_val_trunc
            assign w_value = i_value[DATA_WIDTH-1:0];
        end else begin : g_val_ext
            assign w_value = {{(DATA_WIDTH - PLE_VALUE_W){1'b0}}, i_value};
        end
    endgenerate

    assign w_pos = CMPW'(i_position);
    assign w_cnt = CMPW'(r_count);

    // Row of cells, each handing its entry to a neighbor on a shift
    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++) begin : g_cell
            logic [DATA_WIDTH-1:0] w_left;
            logic [DATA_WIDTH-1:0] w_right;
            if (g == 0) begin : g_first
                assign w_left = w_value;
            end else begin : g_mid_l
                assign w_left = w_data[g-1];
            end
            if (g == CAPACITY - 1) begin : g_last
                assign w_right = '0;
            end else begin : g_mid_r
                assign w_right = w_data[g+1];
            end
            ple_cell #(
                .IDX        (g),
                .DATA_WIDTH (DATA_WIDTH),
                .CMPW       (CMPW)
            ) u_cell (
                .i_clk   (i_clk),
                .i_ctl   (w_ctl),
                .i_pos   (w_pos),
                .i_count (w_cnt),
                .i_value (w_value),
                .i_left  (w_left),
                .i_right (w_right),
                .o_data  (w_data[g]),
                .o_hit   (w_hits[g])
            );
        end
        if (MW > CAPACITY) begin : g_pad
            assign w_hits[MW-1:CAPACITY] = '0;
        end
    endgenerate

    // Handshake
    assign w_take_out = !r_ovalid || !i_out_stall;
    assign o_in_stall = !((r_state == S_IDLE) && w_take_out);
    assign w_accept   = i_in_valid && !o_in_stall;

    // Operation decode, scan and result
    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_mvec   = r_mvec;
        n_base   = r_base;
        n_ovalid = r_ovalid && i_out_stall;
        n_status = r_status;
        n_found  = r_found;
        n_ocount = r_ocount;
        n_empty  = r_empty;
        w_ctl    = '0;

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_ovalid = 1'b1;
                    n_found  = '1;
                    n_status = ST_OK;
                    case (t_opcode'(i_opcode))
                        OP_INSERT: begin
                            if (w_pos > w_cnt) begin
                                n_status = ST_BADPOS;
                            end else if (r_count >= CW'(CAPACITY)) begin
                                n_status = ST_FULL;
                            end else begin
                                w_ctl.ins = 1'b1;
                                n_count   = r_count + CW'(1);
                            end
                        end
                        OP_ERASE: begin
                            if (w_pos >= w_cnt) begin
                                n_status = ST_BADPOS;
                            end else begin
                                w_ctl.ers = 1'b1;
                                n_count   = r_count - CW'(1);
                            end
                        end
                        OP_SEARCH: begin
                            n_ovalid = 1'b0;
                            n_mvec   = w_hits;
                            n_base   = '0;
                            n_state  = S_SCAN;
                        end
                        default: begin
                            n_status = ST_OK;
                        end
                    endcase
                    n_ocount = PLE_POS_W'(n_count);
                    n_empty  = (n_count == '0);
                end
            end
            S_SCAN: begin
                if (r_mvec[PLE_LANES-1:0] != '0) begin
                    if (w_take_out) begin
                        n_ovalid = 1'b1;
                        n_status = ST_OK;
                        n_found  = PLE_POS_W'(r_base
                                   + BW'(ple_first(r_mvec[PLE_LANES-1:0])));
                        n_ocount = PLE_POS_W'(r_count);
                        n_empty  = (r_count == '0);
                        n_state  = S_IDLE;
                    end
                end else if (r_mvec == '0) begin
                    if (w_take_out) begin
                        n_ovalid = 1'b1;
                        n_status = ST_NOTFOUND;
                        n_found  = '1;
                        n_ocount = PLE_POS_W'(r_count);
                        n_empty  = (r_count == '0);
                        n_state  = S_IDLE;
                    end
                end else begin
                    // advance to the next lane group
                    n_mvec = r_mvec >> PLE_LANES;
                    n_base = r_base + BW'(PLE_LANES);
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_ovalid <= n_ovalid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_mvec   <= n_mvec;
        r_base   <= n_base;
        r_status <= n_status;
        r_found  <= n_found;
        r_ocount <= n_ocount;
        r_empty  <= n_empty;
    end

    assign o_out_valid      = r_ovalid;
    assign o_status         = r_status;
    assign o_found_position = r_found;
    assign o_element_count  = r_ocount;
    assign o_is_empty       = r_empty;

endmodule

`default_nettype wire

FILE: rtl/ple_checker.sv
`default_nettype none

module ple_checker #(
    parameter int CAPACITY = ple_pkg::PLE_CAPACITY
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              o_out_valid,
    input  logic                              i_out_stall,
    input  logic [ple_pkg::PLE_STAT_W-1:0]    o_status,
    input  logic signed [ple_pkg::PLE_POS_W-1:0] o_found_position,
    input  logic [ple_pkg::PLE_POS_W-1:0]     o_element_count,
    input  logic                              o_is_empty
);
    import ple_pkg::*;

    // Hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_status)
            && $stable(o_found_position) && $stable(o_element_count))
        else $error("stalled result changed");

    // Only a successful search reports a position
    a_found_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status != ST_OK) |-> (o_found_position == '1))
        else $error("position reported without a match");

    // A reported position lies inside the list
    a_found_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_found_position != '1) |->
            ($unsigned(o_found_position) < o_element_count))
        else $error("match position beyond count");

    // A full report comes only from a full list
    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status == ST_FULL) |->
            (o_element_count == PLE_POS_W'(CAPACITY)) && !o_is_empty)
        else $error("full reported below capacity");

endmodule

bind positional_list_engine_core ple_checker #(.CAPACITY(CAPACITY)) u_ple_checker (.*);

`default_nettype wire
